// ----- rtl/linear_probe_hash_set_unit_macros.svh -----
// Assertion macros shared by the hash set unit RTL.
`ifndef LINEAR_PROBE_HASH_SET_UNIT_MACROS_SVH
`define LINEAR_PROBE_HASH_SET_UNIT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication: when ante holds, cons holds.
`define LPHS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lphs: assertion failed");
// Next-cycle implication: when ante holds, cons holds in the cycle after.
`define LPHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lphs: assertion failed");
`else
`define LPHS_ASSERT_IMP(label, clk, rst, ante, cons)
`define LPHS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/lphs_pkg.sv -----
// Shared widths, operation codes and types for the hash set unit.
package lphs_pkg;

  localparam int OP_W    = 3;
  localparam int KEY_W   = 32;
  localparam int HASH_W  = 32;
  localparam int START_W = 11;
  localparam int SLOT_W  = 10;
  localparam int COUNT_W = 10;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = 10'd768;

  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd3;
  localparam logic [OP_W-1:0] OP_ITERATE = 3'd4;

  // Verdict on one examined slot.
  typedef struct packed {
    logic found;    // key matched, or occupied slot when iterating
    logic is_free;  // never used or tombstone, usable by insert
    logic stop;     // walk ends at this slot
  } slot_chk_t;

endpackage

// ----- rtl/lphs_req_if.sv -----
// Request channel: operation, key, hash and iterate start slot.
interface lphs_req_if;
  import lphs_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [KEY_W-1:0]   key;
  logic [HASH_W-1:0]  hash_value;
  logic [START_W-1:0] start_index;

  modport source (output valid, output operation, output key, output hash_value,
                  output start_index, input ready);
  modport sink (input valid, input operation, input key, input hash_value,
                input start_index, output ready);
endinterface

// ----- rtl/lphs_rsp_if.sv -----
// Response channel: one result transaction per request.
interface lphs_rsp_if;
  import lphs_pkg::*;

  logic               valid;
  logic               ready;
  logic               hit;
  logic [SLOT_W-1:0]  slot_index;
  logic [KEY_W-1:0]   key_out;
  logic               status;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, output hit, output slot_index, output key_out,
                  output status, output entry_count, input ready);
  modport sink (input valid, input hit, input slot_index, input key_out,
                input status, input entry_count, output ready);
endinterface

// ----- rtl/lphs_ram.sv -----
// Generic simple dual-port RAM with registered read.
module lphs_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/lphs_slot_check.sv -----
// Slot examiner: key compare and stop decision for one slot of the walk.
module lphs_slot_check #(
  parameter int KEY_BITS = 32
) (
  input  logic                occupied,
  input  logic                tombstone,
  input  logic [KEY_BITS-1:0] stored_key,
  input  logic [KEY_BITS-1:0] key,
  input  logic                scan_mode,
  input  logic                last_slot,
  output lphs_pkg::slot_chk_t chk
);
  import lphs_pkg::*;

  logic key_match;

  assign key_match = (stored_key == key);

  always_comb begin
    chk = '0;
    if (scan_mode) begin
      chk.found = occupied;
      chk.stop  = occupied || last_slot;
    end else begin
      chk.found   = occupied && key_match;
      chk.is_free = !occupied;
      // a never-used slot ends the chain; a tombstone does not
      chk.stop    = chk.found || (!occupied && !tombstone) || last_slot;
    end
  end
endmodule

// ----- rtl/linear_probe_hash_set_unit.sv -----
// Hash set of keys: open addressing with linear probing and tombstones.
// A request is accepted in S_IDLE, S_SCAN then examines the slots of the walk
// in turn, and S_FINISH writes back and loads the result, waiting while the
// output register still holds a result that was not taken.
// The walk is set by the single read port of the slot RAM, which delivers one
// slot per cycle to the shared key comparator. Iterate scans from start_index
// towards the last slot. Clear and reset both run a clearing pass over all
// SLOTS entries, one per cycle; no request is taken during it, but
// capacity_limit writes are. The unit holds one request at a time; a finished
// result waits in the output register, and the next request is accepted while
// it waits.
`include "linear_probe_hash_set_unit_macros.svh"

module linear_probe_hash_set_unit #(
  parameter int SLOTS    = 1024,
  parameter int KEY_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [lphs_pkg::COUNT_W-1:0] cfg_write_data,
  lphs_req_if.sink                     req,
  lphs_rsp_if.source                   rsp
);
  import lphs_pkg::*;

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int WORD_W = KEY_BITS + 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t              state;
  logic [OP_W-1:0]     op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [IDX_W-1:0]    cur;
  logic [IDX_W-1:0]    steps;
  logic                sweep_reply;
  logic                have_free;
  logic [IDX_W-1:0]    free_at;
  logic                found;
  logic [IDX_W-1:0]    found_at;
  logic [KEY_BITS-1:0] found_key;
  logic [COUNT_W-1:0]  capacity_limit;
  logic [COUNT_W-1:0]  key_count;

  logic                out_valid;
  logic                out_hit;
  logic [SLOT_W-1:0]   out_slot_index;
  logic [KEY_W-1:0]    out_key_out;
  logic                out_status;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  slot_chk_t           chk;
  logic                scan_mode;
  logic                last_slot;
  logic                finish_fire;

  logic                res_hit;
  logic [IDX_W-1:0]    res_slot;
  logic [KEY_BITS-1:0] res_key;
  logic                res_status;
  logic [COUNT_W-1:0]  key_count_next;
  logic                fin_we;
  logic [IDX_W-1:0]    fin_waddr;
  logic [WORD_W-1:0]   fin_wdata;

  assign req.ready = (state == S_IDLE);

  assign rsp.valid       = out_valid;
  assign rsp.hit         = out_hit;
  assign rsp.slot_index  = out_slot_index;
  assign rsp.key_out     = out_key_out;
  assign rsp.status      = out_status;
  assign rsp.entry_count = key_count;

  lphs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign scan_mode = (op_q == OP_ITERATE);
  assign last_slot = scan_mode ? (cur == LAST_IDX) : (steps == LAST_IDX);

  lphs_slot_check #(
    .KEY_BITS (KEY_BITS)
  ) u_check (
    .occupied   (ram_rdata[WORD_W-1]),
    .tombstone  (ram_rdata[WORD_W-2]),
    .stored_key (ram_rdata[KEY_BITS-1:0]),
    .key        (key_q),
    .scan_mode  (scan_mode),
    .last_slot  (last_slot),
    .chk        (chk)
  );

  // Read the home slot while accepting; run one slot ahead while scanning.
  always_comb begin
    if (state == S_SCAN) begin
      ram_raddr = cur + IDX_W'(1);
    end else if (req.operation == OP_ITERATE) begin
      ram_raddr = IDX_W'(req.start_index);
    end else begin
      ram_raddr = req.hash_value[IDX_W-1:0];
    end
  end

  assign finish_fire = (state == S_FINISH) && (!out_valid || rsp.ready);

  always_comb begin
    res_hit        = 1'b0;
    res_slot       = '0;
    res_key        = '0;
    res_status     = 1'b0;
    key_count_next = key_count;
    fin_we         = 1'b0;
    fin_waddr      = found_at;
    fin_wdata      = {1'b0, 1'b1, key_q};
    case (op_q)
      OP_INSERT: begin
        if (found) begin
          res_hit  = 1'b1;
          res_slot = found_at;
          res_key  = found_key;
        end else if (key_count >= capacity_limit || !have_free) begin
          res_status = 1'b1;
        end else begin
          fin_we         = 1'b1;
          fin_waddr      = free_at;
          fin_wdata      = {1'b1, 1'b0, key_q};
          key_count_next = key_count + COUNT_W'(1);
          res_slot       = free_at;
          res_key        = key_q;
        end
      end
      OP_LOOKUP, OP_ITERATE: begin
        if (found) begin
          res_hit  = 1'b1;
          res_slot = found_at;
          res_key  = found_key;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          res_hit  = 1'b1;
          res_slot = found_at;
          res_key  = found_key;
          // leave a tombstone so later chains stay reachable
          fin_we   = 1'b1;
          if (key_count != '0) begin
            key_count_next = key_count - COUNT_W'(1);
          end
        end
      end
      OP_CLEAR: begin
        key_count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (state == S_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = cur;
      ram_wdata = '0;
    end else begin
      ram_we    = finish_fire && fin_we;
      ram_waddr = fin_waddr;
      ram_wdata = fin_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_SWEEP;
      cur            <= '0;
      sweep_reply    <= 1'b0;
      capacity_limit <= LIMIT_RESET;
      key_count      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        capacity_limit <= cfg_write_data;
      end
      // drop the result once taken, unless a new one replaces it
      if (out_valid && rsp.ready && !finish_fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          cur <= cur + IDX_W'(1);
          if (cur == LAST_IDX) begin
            state <= sweep_reply ? S_FINISH : S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            op_q      <= req.operation;
            key_q     <= KEY_BITS'(req.key);
            steps     <= '0;
            have_free <= 1'b0;
            found     <= 1'b0;
            case (req.operation)
              OP_INSERT, OP_LOOKUP, OP_REMOVE: begin
                cur   <= req.hash_value[IDX_W-1:0];
                state <= S_SCAN;
              end
              OP_CLEAR: begin
                cur         <= '0;
                sweep_reply <= 1'b1;
                state       <= S_SWEEP;
              end
              OP_ITERATE: begin
                cur <= IDX_W'(req.start_index);
                if (32'(req.start_index) < SLOTS) begin
                  state <= S_SCAN;
                end else begin
                  state <= S_FINISH;
                end
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (chk.is_free && !have_free) begin
            have_free <= 1'b1;
            free_at   <= cur;
          end
          if (chk.stop) begin
            found     <= chk.found;
            found_at  <= cur;
            found_key <= ram_rdata[KEY_BITS-1:0];
            state     <= S_FINISH;
          end else begin
            cur   <= cur + IDX_W'(1);
            steps <= steps + IDX_W'(1);
          end
        end
        S_FINISH: begin
          // hold until the output register is free
          if (finish_fire) begin
            out_valid      <= 1'b1;
            out_hit        <= res_hit;
            out_slot_index <= SLOT_W'(res_slot);
            out_key_out    <= KEY_W'(res_key);
            out_status     <= res_status;
            key_count      <= key_count_next;
            sweep_reply    <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `LPHS_ASSERT_IMP(a_scan_no_write, clk, rst, state == S_SCAN, !ram_we)
  `LPHS_ASSERT_NEXT(a_clear_sweeps, clk, rst, req.valid && req.ready && req.operation == OP_CLEAR, state == S_SWEEP && sweep_reply)
  `LPHS_ASSERT_IMP(a_refusal_misses, clk, rst, out_valid && out_status, !out_hit && out_slot_index == '0)
  `LPHS_ASSERT_NEXT(a_finish_loads, clk, rst, finish_fire, out_valid && state == S_IDLE)

endmodule
